// ----- hw/rtl/urbs_pkg.sv -----
// Shared types and widths for the key range bucket splitter.
// No dependencies; imported by urbs_div, urbs_emit and the top level.
package urbs_pkg;

  localparam int unsigned KeyW = 64;
  localparam int unsigned CntW = 7;
  localparam int unsigned StepW = 6;

  localparam logic [KeyW-1:0] AllOnes = '1;

  // Range prepared for division
  typedef struct packed {
    logic [KeyW-1:0] span;
    logic [KeyW-1:0] min;
    logic [CntW-1:0] count;
    logic            empty;
  } urbs_job_t;

  // Quotient and extra-bucket count handed to the emitter
  typedef struct packed {
    logic [KeyW-1:0] quot;
    logic [CntW-1:0] extra;
    logic [KeyW-1:0] min;
    logic [CntW-1:0] count;
    logic            empty;
  } urbs_split_t;

  // One result beat
  typedef struct packed {
    logic [KeyW-1:0] lower;
    logic [KeyW-1:0] upper;
    logic            upper_unb;
    logic            empty;
    logic            last;
  } urbs_beat_t;

endpackage

// ----- hw/rtl/urbs_div.sv -----
// Bit-serial restoring divider: span by bucket count, one quotient bit a cycle.
// Depends on urbs_pkg.
module urbs_div import urbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  urbs_job_t   job_i,
  output logic        ready_o,
  output logic        res_valid_o,
  output urbs_split_t res_o,
  input  logic        res_take_i
);

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDone
  } state_e;

  state_e            state_q;
  logic [StepW-1:0]  step_q;
  logic [KeyW-1:0]   quot_q;
  logic [CntW-1:0]   rem_q;
  logic [KeyW-1:0]   min_q;
  logic [CntW-1:0]   count_q;
  logic              empty_q;

  logic [CntW:0]     trial;
  logic              ge;
  logic [CntW-1:0]   rem_d;

  assign trial = {rem_q, quot_q[KeyW-1]};
  assign ge    = trial >= {1'b0, count_q};
  assign rem_d = ge ? CntW'(trial - {1'b0, count_q}) : trial[CntW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= job_i.empty ? StDone : StRun;
            step_q  <= '0;
          end
        end
        StRun: begin
          step_q <= step_q + 1'b1;
          if (step_q == '1) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (res_take_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      quot_q  <= job_i.span;
      rem_q   <= '0;
      min_q   <= job_i.min;
      count_q <= job_i.count;
      empty_q <= job_i.empty;
    end else if (state_q == StRun) begin
      quot_q <= {quot_q[KeyW-2:0], ge};
      rem_q  <= rem_d;
    end
  end

  assign ready_o     = (state_q == StIdle);
  assign res_valid_o = (state_q == StDone);
  assign res_o.quot  = quot_q;
  assign res_o.extra = CntW'(rem_q + 1'b1);
  assign res_o.min   = min_q;
  assign res_o.count = count_q;
  assign res_o.empty = empty_q;

endmodule

// ----- hw/rtl/urbs_emit.sv -----
// Bucket generator: walks the buckets of one split and drives the output register.
// Depends on urbs_pkg.
module urbs_emit import urbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        split_valid_i,
  input  urbs_split_t split_i,
  output logic        split_take_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output urbs_beat_t  m_beat_o
);

  logic             active_q;
  logic             out_valid_q;
  urbs_beat_t       beat_q;
  logic [KeyW-1:0]  next_q;
  logic [KeyW-1:0]  base_q;
  logic [CntW-1:0]  extra_q;
  logic [CntW-1:0]  index_q;
  logic [CntW-1:0]  count_q;
  logic             empty_q;

  logic             produce;
  logic             is_last;
  logic [KeyW-1:0]  size;
  logic [KeyW-1:0]  bucket_end;

  assign split_take_o = !active_q && split_valid_i;
  assign produce      = active_q && (!out_valid_q || m_ready_i);
  assign is_last      = empty_q || (CntW'(index_q + 1'b1) == count_q);
  assign size         = base_q + KeyW'(extra_q != '0);
  assign bucket_end   = next_q + size;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (split_take_o) begin
        active_q <= 1'b1;
      end else if (produce && is_last) begin
        active_q <= 1'b0;
      end
      if (produce) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (split_take_o) begin
      next_q  <= split_i.min;
      base_q  <= split_i.quot;
      extra_q <= split_i.extra;
      index_q <= '0;
      count_q <= split_i.count;
      empty_q <= split_i.empty;
    end else if (produce) begin
      next_q  <= bucket_end;
      index_q <= CntW'(index_q + 1'b1);
      if (extra_q != '0) begin
        extra_q <= CntW'(extra_q - 1'b1);
      end
    end
    if (produce) begin
      if (empty_q) begin
        beat_q <= '{lower: '0, upper: '0, upper_unb: 1'b0, empty: 1'b1, last: 1'b1};
      end else begin
        beat_q <= '{lower: next_q, upper: bucket_end, upper_unb: (bucket_end == '0),
                    empty: 1'b0, last: is_last};
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_beat_o  = beat_q;

endmodule

// ----- hw/rtl/uint_range_bucket_split.sv -----
// Splits a half-open 64-bit key range into evenly sized buckets.
// Use: one beat on the slave stream carries a range and a bucket count; the
// master stream returns one beat per bucket in ascending order, tlast on the
// final one. An empty range returns a single beat with tuser set.
// Bucket count 0 is taken as one, counts above MAX_BUCKETS as MAX_BUCKETS.
// Path: the bit-serial divider (one quotient bit a cycle, 64 steps), the
// handover to the bucket generator, then the output register; after the first
// beat, one bucket beat a cycle while m_axis_tready is high.
// An empty range skips the divider loop and goes to the handover directly.
// Overlap: the divider takes a new range as soon as its previous quotient
// has gone to the bucket generator, so division of the next range overlaps
// emission of the current one.
// Reset: asynchronous, active low; clears the divider and generator state and
// drops any beat in flight.
// Stall: when m_axis_tready is low the output beat holds, bucket generation
// pauses and, once the divider is done, s_axis_tready stays low.
// Depends on urbs_pkg, urbs_div and urbs_emit.
module uint_range_bucket_split import urbs_pkg::*; #(
  parameter int unsigned MAX_BUCKETS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] lower_value, [64] lower_unbounded, [128:65] upper_value,
  // [129] upper_unbounded, [136:130] bucket_count, [143:137] zero
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] bucket_lower, [127:64] bucket_upper, [128] bucket_upper_unbounded,
  // [135:129] zero
  output logic [135:0] m_axis_tdata,
  // [0] empty_error
  output logic [0:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_BUCKETS);

  logic [KeyW-1:0] lower_value;
  logic            lower_unb;
  logic [KeyW-1:0] upper_value;
  logic            upper_unb;
  logic [CntW-1:0] count_in;

  logic [KeyW-1:0] min_inc;
  logic [KeyW-1:0] max_inc;
  urbs_job_t       job;
  logic            div_ready;
  logic            split_valid;
  urbs_split_t     split;
  logic            split_take;
  urbs_beat_t      beat;

  assign lower_value = s_axis_tdata[63:0];
  assign lower_unb   = s_axis_tdata[64];
  assign upper_value = s_axis_tdata[128:65];
  assign upper_unb   = s_axis_tdata[129];
  assign count_in    = s_axis_tdata[136:130];

  assign min_inc = lower_unb ? AllOnes : lower_value;
  assign max_inc = upper_unb ? AllOnes : KeyW'(upper_value - 1'b1);

  always_comb begin
    job.span  = max_inc - min_inc;
    job.min   = min_inc;
    job.empty = !upper_unb && (upper_value <= min_inc);
    priority if (count_in == '0) begin
      job.count = CntW'(1);
    end else if (count_in > MaxCnt) begin
      job.count = MaxCnt;
    end else begin
      job.count = count_in;
    end
  end

  assign s_axis_tready = div_ready;

  urbs_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid && div_ready),
    .job_i       (job),
    .ready_o     (div_ready),
    .res_valid_o (split_valid),
    .res_o       (split),
    .res_take_i  (split_take)
  );

  urbs_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .split_valid_i (split_valid),
    .split_i       (split),
    .split_take_o  (split_take),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_beat_o      (beat)
  );

  assign m_axis_tdata = {7'b0, beat.upper_unb, beat.upper, beat.lower};
  assign m_axis_tuser = beat.empty;
  assign m_axis_tlast = beat.last;

endmodule

// ----- hw/rtl/urbs_checker.sv -----
// Port-level checks for uint_range_bucket_split, attached by bind.
// Depends only on the top level's ports.
module urbs_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  // Hold a stalled output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled output beat changed");

  // Divider is busy right after taking a range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again without division");

  // Error beat is alone and carries zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("malformed empty-range beat");

  // Wrapped end reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[128] |-> (m_axis_tdata[127:64] == '0))
    else $error("unbounded bucket with non-zero upper");

endmodule

bind uint_range_bucket_split urbs_checker u_urbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- bench/uint_range_bucket_split_tb.sv -----
// Testbench for uint_range_bucket_split: drives key ranges on the slave stream and
// checks every bucket beat against a behavioural split of the same range.
// Depends on urbs_pkg and the uint_range_bucket_split RTL.
`timescale 1ns / 100ps

module uint_range_bucket_split_tb import urbs_pkg::*;;

  localparam int unsigned MaxBuckets = 64;

  typedef struct packed {
    logic [KeyW-1:0] lo;
    logic            lo_unb;
    logic [KeyW-1:0] up;
    logic            up_unb;
    logic [CntW-1:0] count;
  } range_req_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // [63:0] lower_value, [64] lower_unbounded, [128:65] upper_value,
  // [129] upper_unbounded, [136:130] bucket_count, [143:137] zero
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [63:0] bucket_lower, [127:64] bucket_upper, [128] bucket_upper_unbounded,
  // [135:129] zero
  logic [135:0] m_axis_tdata;
  // [0] empty_error
  logic [0:0]   m_axis_tuser;
  logic         m_axis_tlast;

  urbs_beat_t   pending_buckets[$];
  urbs_beat_t   want;
  int unsigned  errors = 0;
  int unsigned  stall_left = 0;
  bit           steady = 1'b0;

  uint_range_bucket_split #(.MAX_BUCKETS(MaxBuckets)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (steady || r < 9) return 0;
    if (r < 15) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic range_req_t make_range(logic [KeyW-1:0] lo, logic lo_unb,
                                            logic [KeyW-1:0] up, logic up_unb,
                                            logic [CntW-1:0] count);
    range_req_t r;
    r.lo = lo;
    r.lo_unb = lo_unb;
    r.up = up;
    r.up_unb = up_unb;
    r.count = count;
    return r;
  endfunction

  // Even split, larger buckets first; an end that wraps to zero is unbounded.
  function automatic void split_range(range_req_t r);
    logic [KeyW-1:0] lo_inc, hi_inc, span, base, start, stop;
    logic [CntW-1:0] n, extra;
    urbs_beat_t      b;
    n = r.count;
    if (n == 0) n = 1;
    if (n > MaxBuckets) n = MaxBuckets;
    lo_inc = r.lo_unb ? AllOnes : r.lo;
    if (!r.up_unb && r.up <= lo_inc) begin
      b = '0;
      b.empty = 1'b1;
      b.last = 1'b1;
      pending_buckets = {pending_buckets, b};
      return;
    end
    hi_inc = r.up_unb ? AllOnes : r.up - 1;
    span = hi_inc - lo_inc;
    base = span / n;
    extra = CntW'(span % n) + 1'b1;
    start = lo_inc;
    for (int i = 0; i < n; i++) begin
      stop = start + base;
      if (extra != 0) begin
        stop = stop + 1;
        extra = extra - 1'b1;
      end
      b.lower = start;
      b.upper = stop;
      b.upper_unb = (stop == 0);
      b.empty = 1'b0;
      b.last = (i == n - 1);
      pending_buckets = {pending_buckets, b};
      start = stop;
    end
  endfunction

  task automatic send_range(range_req_t r);
    int unsigned gap;
    s_axis_tdata <= {7'b0, r.count, r.up_unb, r.up, r.lo_unb, r.lo};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    split_range(r);
    gap = pause_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_buckets.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic range_req_t random_range();
    range_req_t r;
    int unsigned kind, c;
    r.lo = rand_key();
    r.up = rand_key();
    r.lo_unb = ($urandom_range(0, 7) == 0);
    r.up_unb = ($urandom_range(0, 5) == 0);
    kind = $urandom_range(0, 9);
    if (kind >= 2 && kind <= 5) begin
      if (kind == 5) r.lo = AllOnes - $urandom_range(0, 200);
      r.up = r.lo + $urandom_range(1, 300);
      r.lo_unb = 1'b0;
    end else if (kind == 6 || kind == 7) begin
      r.lo = {32'b0, $urandom};
      r.lo_unb = 1'b0;
    end else if (kind == 8) begin
      r.up = r.lo - $urandom_range(0, 5);
      r.up_unb = 1'b0;
    end
    c = $urandom_range(0, 19);
    if (c < 14) r.count = CntW'($urandom_range(1, 16));
    else if (c < 19) r.count = CntW'($urandom_range(1, 64));
    else r.count = CntW'($urandom_range(0, 127));
    return r;
  endfunction

  task automatic test_bounds();
    send_range(make_range('0, 1'b0, '0, 1'b1, 7'd1));
    send_range(make_range('0, 1'b0, '0, 1'b1, 7'd64));
    send_range(make_range(rand_key(), 1'b1, rand_key(), 1'b1, 7'd64));
    send_range(make_range('0, 1'b0, AllOnes, 1'b0, 7'd1));
    send_range(make_range(AllOnes - 1, 1'b0, '0, 1'b1, 7'd3));
    send_range(make_range(AllOnes, 1'b0, '0, 1'b1, 7'd2));
    send_range(make_range(64'h8000_0000_0000_0000, 1'b0, AllOnes, 1'b0, 7'd5));
  endtask

  task automatic test_empty();
    send_range(make_range('0, 1'b0, '0, 1'b0, 7'd4));
    send_range(make_range(64'd5, 1'b0, 64'd5, 1'b0, 7'd1));
    send_range(make_range(AllOnes, 1'b0, 64'd7, 1'b0, 7'd9));
    send_range(make_range('0, 1'b1, AllOnes, 1'b0, 7'd2));
    send_range(make_range(AllOnes, 1'b1, '0, 1'b0, 7'd127));
  endtask

  task automatic test_counts();
    send_range(make_range(64'd100, 1'b0, 64'd200, 1'b0, 7'd0));
    send_range(make_range(64'd100, 1'b0, 64'd200, 1'b0, 7'd127));
    send_range(make_range(64'd0, 1'b0, 64'd1000, 1'b0, 7'd65));
    send_range(make_range(64'd10, 1'b0, 64'd13, 1'b0, 7'd7));
    send_range(make_range(64'd0, 1'b0, 64'd64, 1'b0, 7'd64));
    send_range(make_range(64'd0, 1'b0, 64'd100, 1'b0, 7'd7));
    send_range(make_range(AllOnes - 2, 1'b0, '0, 1'b1, 7'd6));
  endtask

  task automatic test_random();
    for (int i = 0; i < 250; i++) begin
      steady = (i >= 100 && i < 130);
      if (i == 60 || i == 180) wait_drained();
      send_range(random_range());
    end
    steady = 1'b0;
  endtask

  function automatic void check_field(string name, logic [KeyW-1:0] exp_v,
                                      logic [KeyW-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left <= pause_len();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_buckets.size() == 0) begin
        errors++;
        $display("%0t: beat with nothing expected, expected none actual %h",
                 $time, m_axis_tdata);
      end else begin
        want = pending_buckets.pop_front();
        check_field("bucket_lower", want.lower, m_axis_tdata[63:0]);
        check_field("bucket_upper", want.upper, m_axis_tdata[127:64]);
        check_field("bucket_upper_unbounded", want.upper_unb, m_axis_tdata[128]);
        check_field("empty_error", want.empty, m_axis_tuser[0]);
        check_field("last", want.last, m_axis_tlast);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bounds();
    test_empty();
    test_counts();
    test_random();
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
